@@ rtl/i2c_master_bit_engine_unit_defines.svh @@
// Assertion macros shared by the RTL.
`ifndef I2C_MASTER_BIT_ENGINE_UNIT_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define I2CBE_ASSERT(lbl, clk_, rstn_, prop) \
	lbl: assert property (@(posedge clk_) disable iff (!rstn_) prop) \
	else $error("i2cbe assertion failed");
`define I2CBE_ASSERT_ALWAYS(lbl, clk_, prop) \
	lbl: assert property (@(posedge clk_) prop) else $error("i2cbe assertion failed");
`else
`define I2CBE_ASSERT(lbl, clk_, rstn_, prop)
`define I2CBE_ASSERT_ALWAYS(lbl, clk_, prop)
`endif
`endif

@@ rtl/i2cbe_pkg.sv @@
`timescale 1ns / 1ps
package i2cbe_pkg;
	localparam int RECOVERY_PULSES = 9;
	localparam logic [6:0] ADDR_LOWEST  = 7'h08;
	localparam logic [6:0] ADDR_HIGHEST = 7'h77;

	localparam logic [2:0] REQ_START   = 3'd1;
	localparam logic [2:0] REQ_RESTART = 3'd2;
	localparam logic [2:0] REQ_WRITE   = 3'd3;
	localparam logic [2:0] REQ_READ    = 3'd4;
	localparam logic [2:0] REQ_STOP    = 3'd5;
	localparam logic [2:0] REQ_RECOVER = 3'd6;

	localparam logic [1:0] LS_IDLE  = 2'd0;
	localparam logic [1:0] LS_BUSY  = 2'd1;
	localparam logic [1:0] LS_ERROR = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_ANACK   = 3'd1;
	localparam logic [2:0] ST_DNACK   = 3'd2;
	localparam logic [2:0] ST_ARB     = 3'd3;
	localparam logic [2:0] ST_TIMEOUT = 3'd4;
	localparam logic [2:0] ST_RANGE   = 3'd5;
	localparam logic [2:0] ST_STUCK   = 3'd6;

	localparam logic [2:0] CFG_HALF    = 3'd0;
	localparam logic [2:0] CFG_DSETUP  = 3'd1;
	localparam logic [2:0] CFG_RSETUP  = 3'd2;
	localparam logic [2:0] CFG_SHOLD   = 3'd3;
	localparam logic [2:0] CFG_PSETUP  = 3'd4;
	localparam logic [2:0] CFG_BFREE   = 3'd5;
	localparam logic [2:0] CFG_TIMEOUT = 3'd6;

	localparam logic [4:0] PH_IDLE     = 5'd0;
	localparam logic [4:0] PH_ST_BUF   = 5'd1;
	localparam logic [4:0] PH_RS_SU1   = 5'd2;
	localparam logic [4:0] PH_RS_SU2   = 5'd3;
	localparam logic [4:0] PH_ST_HOLD  = 5'd4;
	localparam logic [4:0] PH_ST_LOW   = 5'd5;
	localparam logic [4:0] PH_WR_SETUP = 5'd6;
	localparam logic [4:0] PH_CK_RISE  = 5'd7;
	localparam logic [4:0] PH_CK_HIGH  = 5'd8;
	localparam logic [4:0] PH_CK_LOW   = 5'd9;
	localparam logic [4:0] PH_WA_SETUP = 5'd10;
	localparam logic [4:0] PH_WA_HIGH  = 5'd11;
	localparam logic [4:0] PH_WA_LOW   = 5'd12;
	localparam logic [4:0] PH_RD_SETUP = 5'd13;
	localparam logic [4:0] PH_RD_HIGH  = 5'd14;
	localparam logic [4:0] PH_RD_LOW   = 5'd15;
	localparam logic [4:0] PH_RA_SETUP = 5'd16;
	localparam logic [4:0] PH_SP_SU1   = 5'd17;
	localparam logic [4:0] PH_SP_SU2   = 5'd18;
	localparam logic [4:0] PH_SP_BUF   = 5'd19;
	localparam logic [4:0] PH_RC_LOW   = 5'd20;
	localparam logic [4:0] PH_RC_HIGH  = 5'd21;
	localparam logic [4:0] PH_RC_SDA   = 5'd22;

	// zero-length phases that may chain inside one tick
	localparam int CHAIN_STEPS = 6;

	typedef struct packed {
		logic [2:0] req;
		logic       addr_ok;
		logic [7:0] addr_rw;
		logic [7:0] tx;
		logic       ack;
		logic       sda;
		logic       scl;
	} item_t;
endpackage

@@ rtl/i2cbe_front.sv @@
`timescale 1ns / 1ps
`include "i2c_master_bit_engine_unit_defines.svh"
module i2cbe_front import i2cbe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [6:0]  target_addr,
	input  logic        read_dir,
	input  logic [7:0]  tx_byte,
	input  logic        send_ack,
	input  logic        sda_in,
	input  logic        scl_in,
	output logic        q_valid,
	output item_t       q_item,
	input  logic        q_pop
);
	item_t      new_item;
	item_t      head_q, tail_q;
	logic [1:0] cnt_q;
	logic       push;

	always_comb begin
		new_item.req       = req_type;
		new_item.addr_ok   = (target_addr >= ADDR_LOWEST) && (target_addr <= ADDR_HIGHEST);
		new_item.addr_rw   = {target_addr, read_dir};
		new_item.tx        = tx_byte;
		new_item.ack       = send_ack;
		new_item.sda       = sda_in;
		new_item.scl       = scl_in;
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, q_pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, q_pop})
			2'b11: head_q <= new_item;
			2'b01: head_q <= tail_q;
			2'b10: begin
				if (cnt_q == 2'd0) head_q <= new_item;
				else tail_q <= new_item;
			end
			default: head_q <= head_q;
		endcase
	end

	`I2CBE_ASSERT(a_cnt_max, clk, arst_n, cnt_q <= 2'd2)
	`I2CBE_ASSERT(a_pop_nonempty, clk, arst_n, q_pop |-> q_valid)
	`I2CBE_ASSERT(a_full_follows, clk, arst_n, (push && !q_pop && cnt_q == 2'd1) |=> in_stall)
endmodule

@@ rtl/i2cbe_back.sv @@
`timescale 1ns / 1ps
`include "i2c_master_bit_engine_unit_defines.svh"
module i2cbe_back import i2cbe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [23:0] cfg_data,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        scl_out,
	output logic        sda_release,
	output logic        ready_res,
	output logic        done_res,
	output logic [2:0]  status,
	output logic [7:0]  rx_byte,
	output logic [1:0]  bus_state
);
	typedef struct packed {
		logic [15:0] half;
		logic [7:0]  dsetup;
		logic [7:0]  rsetup;
		logic [7:0]  shold;
		logic [7:0]  psetup;
		logic [7:0]  bfree;
		logic [23:0] timeout;
	} cfg_t;

	typedef struct packed {
		logic [4:0]  phase;
		logic [23:0] cnt;
		logic [3:0]  bidx;
		logic [7:0]  shift;
		logic [2:0]  hcmd;
		logic        hack;
		logic [3:0]  pcnt;
		logic [1:0]  ls;
		logic [7:0]  rxb;
		logic        scl_d;
		logic        sda_d;
		logic [2:0]  st;
		logic [2:0]  pend;
		logic        done;
	} eng_t;

	cfg_t cfg_q;
	eng_t eng_q, eng_nx;
	logic out_valid_q;

	function automatic logic cur_bit(eng_t e);
		return e.shift[3'd7 - e.bidx[2:0]];
	endfunction

	function automatic eng_t finish(eng_t e, logic [2:0] st);
		e.phase = PH_IDLE;
		e.st    = st;
		e.done  = 1'b1;
		return e;
	endfunction

	function automatic eng_t enter(eng_t e, logic [4:0] p, cfg_t c);
		e.phase = p;
		case (p)
			PH_ST_BUF: begin e.sda_d = 1'b1; e.scl_d = 1'b1; e.cnt = 24'(c.bfree); end
			PH_RS_SU1: begin e.sda_d = 1'b1; e.cnt = 24'(c.rsetup); end
			PH_RS_SU2: begin e.scl_d = 1'b1; e.cnt = 24'(c.rsetup); end
			PH_ST_HOLD: begin e.sda_d = 1'b0; e.cnt = 24'(c.shold); end
			PH_ST_LOW: begin e.scl_d = 1'b0; e.cnt = 24'(c.half); end
			PH_WR_SETUP: begin e.sda_d = cur_bit(e); e.cnt = 24'(c.dsetup); end
			PH_CK_RISE: begin e.scl_d = 1'b1; e.cnt = '0; end
			PH_CK_HIGH: begin e.cnt = 24'(c.half); end
			PH_CK_LOW: begin e.scl_d = 1'b0; e.cnt = 24'(c.half); end
			PH_WA_SETUP: begin e.sda_d = 1'b1; e.cnt = 24'(c.dsetup); end
			PH_WA_HIGH: begin e.scl_d = 1'b1; e.cnt = 24'(c.half); end
			PH_WA_LOW: begin e.scl_d = 1'b0; e.cnt = 24'(c.half); end
			PH_RD_SETUP: begin e.sda_d = 1'b1; e.cnt = 24'(c.dsetup); end
			PH_RD_HIGH: begin e.scl_d = 1'b1; e.cnt = 24'(c.half); end
			PH_RD_LOW: begin e.scl_d = 1'b0; e.cnt = 24'(c.half); end
			PH_RA_SETUP: begin e.sda_d = !e.hack; e.cnt = 24'(c.dsetup); end
			PH_SP_SU1: begin e.sda_d = 1'b0; e.cnt = 24'(c.psetup); end
			PH_SP_SU2: begin e.scl_d = 1'b1; e.cnt = 24'(c.psetup); end
			PH_SP_BUF: begin e.sda_d = 1'b1; e.cnt = 24'(c.bfree); end
			PH_RC_LOW: begin e.scl_d = 1'b0; e.cnt = 24'(c.half); end
			PH_RC_HIGH: begin e.scl_d = 1'b1; e.cnt = 24'(c.half); end
			PH_RC_SDA: begin e.sda_d = 1'b0; e.cnt = 24'(c.shold); end
			default: begin e.phase = PH_IDLE; e.cnt = '0; end
		endcase
		return e;
	endfunction

	function automatic eng_t fail(eng_t e, logic [2:0] st, cfg_t c);
		if (e.hcmd == REQ_START || e.hcmd == REQ_RESTART) begin
			e.pend = st;
			e = enter(e, PH_SP_SU1, c);
		end else if (e.hcmd == REQ_READ) begin
			e.sda_d = 1'b1;
			e = finish(e, st);
		end else begin
			if (st == ST_ARB) e.ls = LS_ERROR;
			e = finish(e, st);
		end
		return e;
	endfunction

	function automatic eng_t end_phase(eng_t e, logic sda, cfg_t c);
		case (e.phase)
			PH_ST_BUF: e = enter(e, PH_ST_HOLD, c);
			PH_RS_SU1: e = enter(e, PH_RS_SU2, c);
			PH_RS_SU2: e = enter(e, PH_ST_HOLD, c);
			PH_ST_HOLD: e = enter(e, PH_ST_LOW, c);
			PH_ST_LOW: begin e.bidx = '0; e = enter(e, PH_WR_SETUP, c); end
			PH_WR_SETUP: begin
				if (cur_bit(e) && !sda) e = fail(e, ST_ARB, c);
				else e = enter(e, PH_CK_RISE, c);
			end
			PH_CK_HIGH: e = enter(e, PH_CK_LOW, c);
			PH_CK_LOW: begin
				if (e.hcmd == REQ_READ) begin
					e.sda_d = 1'b1;
					e = finish(e, ST_OK);
				end else begin
					e.bidx = e.bidx + 4'd1;
					e = enter(e, (e.bidx < 4'd8) ? PH_WR_SETUP : PH_WA_SETUP, c);
				end
			end
			PH_WA_SETUP: e = enter(e, PH_WA_HIGH, c);
			PH_WA_HIGH: begin e.hack = sda; e = enter(e, PH_WA_LOW, c); end
			PH_WA_LOW: begin
				if (e.hcmd == REQ_START || e.hcmd == REQ_RESTART) begin
					if (e.hack) e = fail(e, ST_ANACK, c);
					else e = finish(e, ST_OK);
				end else begin
					e = finish(e, e.hack ? ST_DNACK : ST_OK);
				end
			end
			PH_RD_SETUP: e = enter(e, PH_RD_HIGH, c);
			PH_RD_HIGH: begin e.shift = {e.shift[6:0], sda}; e = enter(e, PH_RD_LOW, c); end
			PH_RD_LOW: begin
				e.bidx = e.bidx + 4'd1;
				if (e.bidx < 4'd8) begin
					e = enter(e, PH_RD_SETUP, c);
				end else begin
					e.rxb = e.shift;
					e = enter(e, PH_RA_SETUP, c);
				end
			end
			PH_RA_SETUP: e = enter(e, PH_CK_RISE, c);
			PH_SP_SU1: e = enter(e, PH_SP_SU2, c);
			PH_SP_SU2: e = enter(e, PH_SP_BUF, c);
			PH_SP_BUF: begin
				if (e.hcmd == REQ_RECOVER) begin
					if (!sda) begin e.ls = LS_ERROR; e = finish(e, ST_STUCK); end
					else begin e.ls = LS_IDLE; e = finish(e, ST_OK); end
				end else begin
					e.ls = LS_IDLE;
					e = finish(e, e.pend);
				end
			end
			PH_RC_LOW: e = enter(e, PH_RC_HIGH, c);
			PH_RC_HIGH: begin
				if ({1'b0, e.pcnt} + 5'd1 >= 5'(RECOVERY_PULSES)) begin
					e = enter(e, PH_RC_SDA, c);
				end else begin
					e.pcnt = e.pcnt + 4'd1;
					e = enter(e, PH_RC_LOW, c);
				end
			end
			PH_RC_SDA: e = enter(e, PH_SP_SU2, c);
			default: e.phase = PH_IDLE;
		endcase
		return e;
	endfunction

	function automatic eng_t take_cmd(eng_t e, item_t it, cfg_t c);
		if (it.req >= REQ_START && it.req <= REQ_RECOVER) begin
			e.hcmd = it.req;
			e.bidx = '0;
			e.pcnt = '0;
			case (it.req)
				REQ_START, REQ_RESTART: begin
					if (!it.addr_ok) begin
						e = finish(e, ST_RANGE);
					end else begin
						e.shift = it.addr_rw;
						if (it.req == REQ_START) begin
							e.ls = LS_BUSY;
							e = enter(e, PH_ST_BUF, c);
						end else begin
							e = enter(e, PH_RS_SU1, c);
						end
					end
				end
				REQ_WRITE: begin e.shift = it.tx; e = enter(e, PH_WR_SETUP, c); end
				REQ_READ: begin
					e.hack = it.ack;
					e.shift = '0;
					e = enter(e, PH_RD_SETUP, c);
				end
				REQ_STOP: begin e.pend = ST_OK; e = enter(e, PH_SP_SU1, c); end
				default: e = enter(e, PH_RC_LOW, c);
			endcase
		end
		return e;
	endfunction

	// one tick: counter update, then any zero-length phases that follow
	always_comb begin
		eng_nx = eng_q;
		eng_nx.done = 1'b0;
		if (eng_nx.phase == PH_IDLE) begin
			eng_nx = take_cmd(eng_nx, q_item, cfg_q);
		end else if (eng_nx.phase == PH_CK_RISE) begin
			if (q_item.scl) begin
				eng_nx = enter(eng_nx, PH_CK_HIGH, cfg_q);
			end else begin
				eng_nx.cnt = eng_nx.cnt + 24'd1;
				if (eng_nx.cnt >= cfg_q.timeout) eng_nx = fail(eng_nx, ST_TIMEOUT, cfg_q);
			end
		end else if (eng_nx.cnt != '0) begin
			eng_nx.cnt = eng_nx.cnt - 24'd1;
		end
		for (int i = 0; i < CHAIN_STEPS; i++) begin
			if (eng_nx.phase != PH_IDLE && eng_nx.phase != PH_CK_RISE && eng_nx.cnt == '0)
				eng_nx = end_phase(eng_nx, q_item.sda, cfg_q);
		end
	end

	assign q_pop     = q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{half: 16'd5, dsetup: 8'd1, rsetup: 8'd5, shold: 8'd4,
				psetup: 8'd4, bfree: 8'd5, timeout: 24'd10000};
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_HALF: cfg_q.half <= cfg_data[15:0];
				CFG_DSETUP: cfg_q.dsetup <= cfg_data[7:0];
				CFG_RSETUP: cfg_q.rsetup <= cfg_data[7:0];
				CFG_SHOLD: cfg_q.shold <= cfg_data[7:0];
				CFG_PSETUP: cfg_q.psetup <= cfg_data[7:0];
				CFG_BFREE: cfg_q.bfree <= cfg_data[7:0];
				CFG_TIMEOUT: cfg_q.timeout <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_q <= '{scl_d: 1'b1, sda_d: 1'b1, default: '0};
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				eng_q <= eng_nx;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			scl_out     <= eng_nx.scl_d;
			sda_release <= eng_nx.sda_d;
			ready_res   <= (eng_nx.phase == PH_IDLE);
			done_res    <= eng_nx.done;
			status      <= eng_nx.st;
			rx_byte     <= eng_nx.rxb;
			bus_state   <= eng_nx.ls;
		end
	end

	`I2CBE_ASSERT(a_done_idle, clk, arst_n, (out_valid && done_res) |-> ready_res)
	`I2CBE_ASSERT(a_ls_legal, clk, arst_n, eng_q.ls != 2'd3)
	`I2CBE_ASSERT(a_phase_legal, clk, arst_n, eng_q.phase <= PH_RC_SDA)
endmodule

@@ rtl/i2c_master_bit_engine_unit.sv @@
`timescale 1ns / 1ps
// Single-master I2C bit engine. Each input beat is one time tick carrying the
// sampled SDA/SCL levels and an optional command (start/restart with a 7-bit
// address, write byte, read byte with ACK/NACK, stop, bus recovery); each tick
// yields exactly one output beat with the SCL/SDA drives and status. One beat
// is taken per clock while in_stall is low: a two-entry queue sits between the
// input side and the phase engine, and the engine's output register can hold a
// result while the next tick is queued. Timing registers are written through
// cfg_we/cfg_idx/cfg_data, by the user only while the block is idle; the block
// does not enforce this. A beat passes the queue, then the output register.
module i2c_master_bit_engine_unit import i2cbe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [6:0]  target_addr,
	input  logic        read_dir,
	input  logic [7:0]  tx_byte,
	input  logic        send_ack,
	input  logic        sda_in,
	input  logic        scl_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        scl_out,
	output logic        sda_release,
	output logic        ready_res,
	output logic        done_res,
	output logic [2:0]  status,
	output logic [7:0]  rx_byte,
	output logic [1:0]  bus_state
);
	logic  q_valid, q_pop;
	item_t q_item;

	i2cbe_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .target_addr(target_addr), .read_dir(read_dir),
		.tx_byte(tx_byte), .send_ack(send_ack), .sda_in(sda_in), .scl_in(scl_in),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	i2cbe_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.out_valid(out_valid), .out_stall(out_stall), .scl_out(scl_out),
		.sda_release(sda_release), .ready_res(ready_res), .done_res(done_res),
		.status(status), .rx_byte(rx_byte), .bus_state(bus_state)
	);
endmodule
